@@ rtl/tcfifo_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers for the two-class oldest-first fifo
// no dependencies; every other file refers to this package by scoped names
package tcfifo_pkg;

    // sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int STAMP_BITS  = 16;

    // fixed port field widths
    localparam int OPCODE_W = 2;
    localparam int IO_ID_W  = 16;
    localparam int STATUS_W = 2;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PTR_BITS-1:0]   t_ptr;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [CNT_BITS:0]     t_sum;
    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [OPCODE_W-1:0]   t_opcode;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [IO_ID_W-1:0]    t_io_id;

    // opcodes
    localparam t_opcode OP_ENQ     = 2'd0;
    localparam t_opcode OP_DEQ0    = 2'd1;
    localparam t_opcode OP_DEQ1    = 2'd2;
    localparam t_opcode OP_DEQ_ANY = 2'd3;

    // result status codes
    localparam t_status ST_ENQ   = 2'd0;
    localparam t_status ST_DEQ   = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

    // one queue entry
    typedef struct packed {
        t_id    id;
        t_stamp stamp;
    } t_entry;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load;    // capture the accepted request
        logic    finish;  // register the result
        logic    push;    // write the request into its class queue
        logic    pop;     // remove the selected head
        t_status status;
    } t_cmd;

    // datapath to controller, valid while a request is held
    typedef struct packed {
        logic is_enq;
        logic enq_full;
        logic take_empty;
    } t_sts;

    // port id to stored id: keep the low ID_BITS bits
    function automatic t_id to_store_id(input t_io_id x);
        t_id r;
        for (int i = 0; i < ID_BITS; i++) begin
            r[i] = (i < IO_ID_W) ? x[i] : 1'b0;
        end
        return r;
    endfunction

    // stored id to port id: low IO_ID_W bits, zero filled
    function automatic t_io_id to_port_id(input t_id x);
        t_io_id r;
        for (int i = 0; i < IO_ID_W; i++) begin
            r[i] = (i < ID_BITS) ? x[i] : 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/tcfifo_if.sv @@
`timescale 1ns / 1ps
// request and response channel interfaces with valid/ready handshake
// depends on tcfifo_pkg for field types
interface tcfifo_req_if;
    logic                   valid;
    logic                   ready;
    tcfifo_pkg::t_opcode    opcode;
    logic                   item_class;
    tcfifo_pkg::t_io_id     item_id;

    modport source (output valid, output opcode, output item_class, output item_id,
                    input ready);
    modport sink   (input valid, input opcode, input item_class, input item_id,
                    output ready);
endinterface

interface tcfifo_rsp_if;
    logic                   valid;
    logic                   ready;
    tcfifo_pkg::t_status    status;
    logic                   out_class;
    tcfifo_pkg::t_io_id     out_id;

    modport source (output valid, output status, output out_class, output out_id,
                    input ready);
    modport sink   (input valid, input status, input out_class, input out_id,
                    output ready);
endinterface

@@ rtl/tcfifo_ctrl.sv @@
`timescale 1ns / 1ps
// controller: request handshake, execute step, response valid register
// depends on tcfifo_pkg
module tcfifo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    input  tcfifo_pkg::t_sts   i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output tcfifo_pkg::t_cmd   o_cmd
);

    tcfifo_pkg::t_state r_state, n_state;
    logic               r_out_vld, n_out_vld;
    logic               w_fire;

    // execute may complete once the response register is free or draining
    assign w_fire = (r_state == tcfifo_pkg::S_EXEC) && (!r_out_vld || i_out_ready);

    assign o_in_ready  = (r_state == tcfifo_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;

    // command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = o_in_ready && i_in_valid;
        o_cmd.finish = w_fire;
        if (i_sts.is_enq) begin
            o_cmd.push   = w_fire && !i_sts.enq_full;
            o_cmd.status = i_sts.enq_full ? tcfifo_pkg::ST_FULL : tcfifo_pkg::ST_ENQ;
        end else begin
            o_cmd.pop    = w_fire && !i_sts.take_empty;
            o_cmd.status = i_sts.take_empty ? tcfifo_pkg::ST_EMPTY : tcfifo_pkg::ST_DEQ;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcfifo_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tcfifo_pkg::S_EXEC;
                end
            end
            tcfifo_pkg::S_EXEC: begin
                if (w_fire) begin
                    n_state = tcfifo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcfifo_pkg::S_IDLE;
            end
        endcase
    end

    // response valid: set on a finished step, cleared on a transfer
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_fire) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcfifo_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

@@ rtl/tcfifo_dp.sv @@
`timescale 1ns / 1ps
// datapath: two class queues, stamp counter, age compare, response register
// depends on tcfifo_pkg
module tcfifo_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcfifo_pkg::t_opcode  i_opcode,
    input  logic                 i_item_class,
    input  tcfifo_pkg::t_io_id   i_item_id,
    input  tcfifo_pkg::t_cmd     i_cmd,
    output tcfifo_pkg::t_sts     o_sts,
    output tcfifo_pkg::t_status  o_status,
    output logic                 o_out_class,
    output tcfifo_pkg::t_io_id   o_out_id
);

    // queue storage
    tcfifo_pkg::t_entry  r_mem0 [tcfifo_pkg::QUEUE_DEPTH];
    tcfifo_pkg::t_entry  r_mem1 [tcfifo_pkg::QUEUE_DEPTH];
    tcfifo_pkg::t_entry  r_rd0, r_rd1;

    // held request
    tcfifo_pkg::t_opcode r_op;
    logic                r_cls;
    tcfifo_pkg::t_id     r_id;

    // queue control
    tcfifo_pkg::t_ptr    r_head0, r_head1;
    tcfifo_pkg::t_cnt    r_count0, r_count1;
    tcfifo_pkg::t_stamp  r_stamp;

    // response register
    tcfifo_pkg::t_status r_status;
    logic                r_out_class;
    tcfifo_pkg::t_io_id  r_out_id;

    logic                w_empty0, w_empty1, w_full0, w_full1;
    logic                w_take;
    tcfifo_pkg::t_stamp  w_diff;
    tcfifo_pkg::t_ptr    w_tail;
    tcfifo_pkg::t_ptr    w_head_sel;
    tcfifo_pkg::t_cnt    w_count_sel;
    tcfifo_pkg::t_sum    w_sum;
    tcfifo_pkg::t_entry  w_wr;
    logic                w_push0, w_push1, w_pop0, w_pop1;

    assign w_empty0 = (r_count0 == '0);
    assign w_empty1 = (r_count1 == '0);
    assign w_full0  = (r_count0 == tcfifo_pkg::t_cnt'(tcfifo_pkg::QUEUE_DEPTH));
    assign w_full1  = (r_count1 == tcfifo_pkg::t_cnt'(tcfifo_pkg::QUEUE_DEPTH));

    // oldest-first choice: class 0 wins when its stamp is strictly behind, mod wrap
    assign w_diff = r_rd1.stamp - r_rd0.stamp;

    always_comb begin
        case (r_op)
            tcfifo_pkg::OP_DEQ0: w_take = 1'b0;
            tcfifo_pkg::OP_DEQ1: w_take = 1'b1;
            default: begin
                if (w_empty0) begin
                    w_take = 1'b1;
                end else if (w_empty1) begin
                    w_take = 1'b0;
                end else begin
                    w_take = !((w_diff != '0) && !w_diff[tcfifo_pkg::STAMP_BITS-1]);
                end
            end
        endcase
    end

    assign o_sts.is_enq     = (r_op == tcfifo_pkg::OP_ENQ);
    assign o_sts.enq_full   = r_cls ? w_full1 : w_full0;
    assign o_sts.take_empty = w_take ? w_empty1 : w_empty0;

    // tail of the target queue: head plus count, wrapped at the depth
    assign w_head_sel  = r_cls ? r_head1 : r_head0;
    assign w_count_sel = r_cls ? r_count1 : r_count0;
    assign w_sum = tcfifo_pkg::t_sum'(w_head_sel) + tcfifo_pkg::t_sum'(w_count_sel);
    assign w_tail = (w_sum >= tcfifo_pkg::t_sum'(tcfifo_pkg::QUEUE_DEPTH))
                  ? tcfifo_pkg::t_ptr'(w_sum - tcfifo_pkg::t_sum'(tcfifo_pkg::QUEUE_DEPTH))
                  : tcfifo_pkg::t_ptr'(w_sum);

    assign w_wr.id    = r_id;
    assign w_wr.stamp = r_stamp;

    assign w_push0 = i_cmd.push && !r_cls;
    assign w_push1 = i_cmd.push &&  r_cls;
    assign w_pop0  = i_cmd.pop  && !w_take;
    assign w_pop1  = i_cmd.pop  &&  w_take;

    // queue memories with registered head read
    always_ff @(posedge i_clk) begin
        if (w_push0) begin
            r_mem0[w_tail] <= w_wr;
        end
        r_rd0 <= r_mem0[r_head0];
    end

    always_ff @(posedge i_clk) begin
        if (w_push1) begin
            r_mem1[w_tail] <= w_wr;
        end
        r_rd1 <= r_mem1[r_head1];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_cls <= i_item_class;
            r_id  <= tcfifo_pkg::to_store_id(i_item_id);
        end
    end

    // heads, counts and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0  <= '0;
            r_head1  <= '0;
            r_count0 <= '0;
            r_count1 <= '0;
            r_stamp  <= '0;
        end else begin
            if (i_cmd.push) begin
                r_stamp <= r_stamp + tcfifo_pkg::t_stamp'(1);
            end
            if (w_push0) begin
                r_count0 <= r_count0 + tcfifo_pkg::t_cnt'(1);
            end else if (w_pop0) begin
                r_count0 <= r_count0 - tcfifo_pkg::t_cnt'(1);
                r_head0  <= (r_head0 == tcfifo_pkg::t_ptr'(tcfifo_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_head0 + tcfifo_pkg::t_ptr'(1);
            end
            if (w_push1) begin
                r_count1 <= r_count1 + tcfifo_pkg::t_cnt'(1);
            end else if (w_pop1) begin
                r_count1 <= r_count1 - tcfifo_pkg::t_cnt'(1);
                r_head1  <= (r_head1 == tcfifo_pkg::t_ptr'(tcfifo_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_head1 + tcfifo_pkg::t_ptr'(1);
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status    <= i_cmd.status;
            r_out_class <= i_cmd.pop ? w_take : 1'b0;
            if (i_cmd.pop) begin
                r_out_id <= tcfifo_pkg::to_port_id(w_take ? r_rd1.id : r_rd0.id);
            end else begin
                r_out_id <= '0;
            end
        end
    end

    assign o_status    = r_status;
    assign o_out_class = r_out_class;
    assign o_out_id    = r_out_id;

endmodule

@@ rtl/two_class_fifo_oldest_first_unit.sv @@
`timescale 1ns / 1ps
// two-class fifo with oldest-first dequeue, top level
// the request is captured on its transfer; the execute step then writes the response register and
// sets response valid once that register is free or draining, and only then is a new request taken;
// the execute step uses the registered head read of the queue memories, and a new request is taken
// while the previous response waits in its output register
// reset (synchronous, active low) empties both queues and clears the stamp counter
module two_class_fifo_oldest_first_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcfifo_req_if.sink   i_req,
    tcfifo_rsp_if.source o_rsp
);

    tcfifo_pkg::t_cmd w_cmd;
    tcfifo_pkg::t_sts w_sts;
    logic             w_in_ready;
    logic             w_out_valid;

    // handshake and sequencing
    tcfifo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // queues and result
    tcfifo_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_req.opcode),
        .i_item_class (i_req.item_class),
        .i_item_id    (i_req.item_id),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_status     (o_rsp.status),
        .o_out_class  (o_rsp.out_class),
        .o_out_id     (o_rsp.out_id)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

endmodule
